// File: design/qwfc_pkg.sv
// Package for the quadrotor waypoint flight control block.
// Holds field widths, register codes, the mission waypoint table and shared types.
// No dependencies.
package qwfc_pkg;

  localparam int unsigned WAYPOINT_COUNT_DEF = 15;
  localparam int unsigned FRAC_BITS_DEF      = 12;

  localparam int unsigned DATA_W    = 24;
  localparam int unsigned GAIN_W    = 23;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned CFG_IDX_W = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HOVER      = 3'd0,
    CFG_ALT_OFS    = 3'd1,
    CFG_VERT_GAIN  = 3'd2,
    CFG_ROLL_GAIN  = 3'd3,
    CFG_PITCH_GAIN = 3'd4
  } cfg_reg_e;

  // status of the serial multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  // mission waypoints in half meters: {x, y, altitude}, 4 bits each
  function automatic logic [11:0] wp_row(input logic [IDX_W-1:0] row);
    logic [11:0] r;
    unique case (row)
      4'd0:    r = {4'd1, 4'd7, 4'd2};
      4'd1:    r = {4'd1, 4'd1, 4'd4};
      4'd2:    r = {4'd2, 4'd1, 4'd4};
      4'd3:    r = {4'd2, 4'd7, 4'd4};
      4'd4:    r = {4'd3, 4'd7, 4'd4};
      4'd5:    r = {4'd3, 4'd1, 4'd4};
      4'd6:    r = {4'd4, 4'd1, 4'd4};
      4'd7:    r = {4'd4, 4'd7, 4'd4};
      4'd8:    r = {4'd5, 4'd7, 4'd4};
      4'd9:    r = {4'd5, 4'd1, 4'd4};
      4'd10:   r = {4'd6, 4'd1, 4'd4};
      4'd11:   r = {4'd6, 4'd7, 4'd4};
      4'd12:   r = {4'd7, 4'd7, 4'd4};
      4'd13:   r = {4'd7, 4'd1, 4'd4};
      default: r = {4'd1, 4'd7, 4'd4};
    endcase
    return r;
  endfunction

endpackage

// File: design/qwfc_ser_mul.sv
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on qwfc_pkg (mul_stat_t).
module qwfc_ser_mul #(
  parameter int unsigned MW = 25
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [MW-1:0]         a_i,
  input  logic [MW-1:0]         b_i,
  output qwfc_pkg::mul_stat_t   stat_o,
  output logic [2*MW-1:0]       prod_o
);
  import qwfc_pkg::*;

  localparam int unsigned CW = $clog2(MW + 1);

  logic [MW-1:0] a_q, acc_q, bsh_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [MW:0]   sum;

  // one partial product per cycle
  always_comb begin
    sum = {1'b0, acc_q} + (bsh_q[0] ? {1'b0, a_q} : '0);
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(MW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // product shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      bsh_q <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= sum[MW:1];
      bsh_q <= {sum[0], bsh_q[MW-1:1]};
    end
  end

  assign prod_o      = {acc_q, bsh_q};
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> !busy_q)
    else $error("multiplier started while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |=> !done_q)
    else $error("done held longer than one cycle");
  a_busy_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> cnt_q != '0)
    else $error("busy with empty step count");

endmodule

// File: design/quadrotor_waypoint_flight_control.sv
// Top level of the quadrotor waypoint flight control block.
// Depends on qwfc_pkg and qwfc_ser_mul.
//
// Usage:
//  Input channel (in_valid_i / in_stall_o) carries one control tick: angles,
//  position and rates. Output channel (out_valid_o / out_stall_i) returns one
//  result per tick: four motor speeds, camera roll, waypoint index, reached
//  and done flags. A transfer happens when valid is high and stall is low.
//  Config writes (cfg_valid_i / cfg_ready_o) are always taken; index 0..4
//  select hover thrust, altitude offset, vertical, roll and pitch gain.
//  Each tick runs eight products back to back through the one shared
//  bit-serial multiplier, MW bits wide, MW = max(2*FRAC_BITS+1, 24).
//  A new tick is taken once the previous one has left the sequencer; its
//  result waits in the output register while the next tick is in flight.
//  If the receiver stalls, the finished result is held and the sequencer
//  waits at its last step until the output register frees up.
//  Reset: waypoint index and done flag clear, configuration registers load their defaults.
module quadrotor_waypoint_flight_control #(
  parameter int unsigned WAYPOINT_COUNT = qwfc_pkg::WAYPOINT_COUNT_DEF,
  parameter int unsigned FRAC_BITS      = qwfc_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [qwfc_pkg::DATA_W-1:0]     roll_angle_i,
  input  logic signed [qwfc_pkg::DATA_W-1:0]     pitch_angle_i,
  input  logic signed [qwfc_pkg::DATA_W-1:0]     pos_x_i,
  input  logic signed [qwfc_pkg::DATA_W-1:0]     pos_y_i,
  input  logic signed [qwfc_pkg::DATA_W-1:0]     pos_alt_i,
  input  logic signed [qwfc_pkg::DATA_W-1:0]     roll_rate_i,
  input  logic signed [qwfc_pkg::DATA_W-1:0]     pitch_rate_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [qwfc_pkg::DATA_W-1:0]     front_left_speed_o,
  output logic signed [qwfc_pkg::DATA_W-1:0]     front_right_speed_o,
  output logic signed [qwfc_pkg::DATA_W-1:0]     rear_left_speed_o,
  output logic signed [qwfc_pkg::DATA_W-1:0]     rear_right_speed_o,
  output logic signed [qwfc_pkg::DATA_W-1:0]     camera_roll_o,
  output logic [qwfc_pkg::IDX_W-1:0]             target_index_o,
  output logic                                   point_reached_o,
  output logic                                   mission_done_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [qwfc_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [qwfc_pkg::DATA_W-1:0]            cfg_data_i
);
  import qwfc_pkg::*;

  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned MW  = (2 * F + 1 > 24) ? 2 * F + 1 : 24;
  localparam int unsigned PW  = 2 * MW;
  localparam int unsigned RW  = PW + 2;
  localparam int unsigned EW  = DATA_W + 1;
  localparam int unsigned CWD = F + 2;
  localparam int unsigned DW  = F + 3;
  localparam int unsigned TW  = 27;
  localparam int unsigned SW  = 30;
  localparam int          ONE_I = 1 << F;
  localparam int          CAM_GAIN = ((23 << F) + 100) / 200;

  localparam logic signed [EW+1:0] TWO_E  = (EW + 2)'(2 * ONE_I);
  localparam logic signed [EW+1:0] ONE_E  = (EW + 2)'(ONE_I);
  localparam logic signed [RW-1:0] HALF_F = RW'(1) <<< (F - 1);
  localparam logic signed [RW-1:0] HALF_2F = RW'(1) <<< (2 * F - 1);

  localparam logic [GAIN_W-1:0] HOVER_RST = GAIN_W'((137 << F) >> 1);
  localparam logic [DATA_W-1:0] OFS_RST   = DATA_W'(((6 << F) + 5) / 10);
  localparam logic [GAIN_W-1:0] VERT_RST  = GAIN_W'(3 << F);
  localparam logic [GAIN_W-1:0] ROLL_RST  = GAIN_W'(50 << F);
  localparam logic [GAIN_W-1:0] PITCH_RST = GAIN_W'(30 << F);

  typedef enum logic [2:0] {S_IDLE, S_PREP, S_START, S_WAIT, S_FIN} state_e;

  typedef enum logic [2:0] {
    J_SQ, J_CUBE, J_VERT, J_ROLL, J_PITCH, J_CAM, J_DX2, J_DY2
  } job_e;

  state_e state_q;
  job_e   job_q;

  // configuration registers
  logic [GAIN_W-1:0]        hover_q, vgain_q, rgain_q, pgain_q;
  logic signed [DATA_W-1:0] ofs_q;

  // captured tick and intermediate values
  logic signed [DATA_W-1:0] roll_q, pitch_q, px_q, py_q, palt_q, rrate_q, prate_q;
  logic signed [CWD-1:0]    c_q, clr_q, clp_q;
  logic signed [DW-1:0]     pdist_q, rdist_q;
  logic [F-1:0]             exs_q, eys_q;
  logic                     alt_ok_q;
  logic [MW-1:0]            sq_q, dx2_q, dy2_q;
  logic signed [TW-1:0]     c3_q, vert_q, rterm_q, pterm_q, cam_q;

  // state and outputs
  logic [IDX_W-1:0] idx_q;
  logic             done_q;
  logic             out_valid_q;

  mul_stat_t   mstat;
  logic        mul_start;
  logic [MW-1:0] mul_a, mul_b;
  logic        mul_neg;
  logic [PW-1:0] prod;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign mul_start   = (state_q == S_START);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hover_q <= HOVER_RST;
      ofs_q   <= OFS_RST;
      vgain_q <= VERT_RST;
      rgain_q <= ROLL_RST;
      pgain_q <= PITCH_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_HOVER:      hover_q <= cfg_data_i[GAIN_W-1:0];
        CFG_ALT_OFS:    ofs_q   <= cfg_data_i;
        CFG_VERT_GAIN:  vgain_q <= cfg_data_i[GAIN_W-1:0];
        CFG_ROLL_GAIN:  rgain_q <= cfg_data_i[GAIN_W-1:0];
        CFG_PITCH_GAIN: pgain_q <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // errors toward the current waypoint, clamps and altitude test
  logic [11:0]              row;
  logic signed [EW-1:0]     ex, ey, ealt;
  logic signed [EW+1:0]     n2ex, p2ey, ec, rl, pt;
  logic signed [DW-1:0]     pdist, rdist;
  logic signed [CWD-1:0]    c_cl, clr, clp;
  logic [EW-1:0]            exm, eym, altm;
  logic [F-1:0]             exs, eys;
  logic [EW+3:0]            alt10;

  always_comb begin
    row  = wp_row(idx_q);
    ex   = (EW'(row[11:8]) <<< (F - 1)) - EW'(px_q);
    ey   = (EW'(row[7:4]) <<< (F - 1)) - EW'(py_q);
    ealt = (EW'(row[3:0]) <<< (F - 1)) - EW'(palt_q);
    n2ex = -((EW + 2)'(ex) <<< 1);
    p2ey = (EW + 2)'(ey) <<< 1;
    ec   = (EW + 2)'(ealt) + (EW + 2)'(ofs_q);
    rl   = (EW + 2)'(roll_q);
    pt   = (EW + 2)'(pitch_q);
    pdist = (n2ex > TWO_E) ? DW'(TWO_E) : (n2ex < -TWO_E) ? DW'(-TWO_E) : DW'(n2ex);
    rdist = (p2ey > TWO_E) ? DW'(TWO_E) : (p2ey < -TWO_E) ? DW'(-TWO_E) : DW'(p2ey);
    c_cl  = (ec > ONE_E) ? CWD'(ONE_E) : (ec < -ONE_E) ? CWD'(-ONE_E) : CWD'(ec);
    clr   = (rl > ONE_E) ? CWD'(ONE_E) : (rl < -ONE_E) ? CWD'(-ONE_E) : CWD'(rl);
    clp   = (pt > ONE_E) ? CWD'(ONE_E) : (pt < -ONE_E) ? CWD'(-ONE_E) : CWD'(pt);
    exm  = ex[EW-1] ? EW'(-ex) : EW'(ex);
    eym  = ey[EW-1] ? EW'(-ey) : EW'(ey);
    altm = ealt[EW-1] ? EW'(-ealt) : EW'(ealt);
    // past one unit the distance test fails anyway, so saturate
    exs  = (exm >= EW'(ONE_I)) ? F'(ONE_I - 1) : exm[F-1:0];
    eys  = (eym >= EW'(ONE_I)) ? F'(ONE_I - 1) : eym[F-1:0];
    alt10 = ((EW + 4)'(altm) << 3) + ((EW + 4)'(altm) << 1);
  end

  // operand select for the shared multiplier
  logic [CWD-1:0] cmag, clrm, clpm;
  logic [TW-1:0]  c3m;
  logic [DATA_W-1:0] rrm;

  always_comb begin
    cmag = c_q[CWD-1] ? CWD'(-c_q) : CWD'(c_q);
    clrm = clr_q[CWD-1] ? CWD'(-clr_q) : CWD'(clr_q);
    clpm = clp_q[CWD-1] ? CWD'(-clp_q) : CWD'(clp_q);
    c3m  = c3_q[TW-1] ? TW'(-c3_q) : TW'(c3_q);
    rrm  = rrate_q[DATA_W-1] ? DATA_W'(-rrate_q) : DATA_W'(rrate_q);
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    case (job_q)
      J_SQ:    begin mul_a = MW'(cmag);    mul_b = MW'(cmag); end
      J_CUBE:  begin mul_a = sq_q;         mul_b = MW'(cmag); mul_neg = c_q[CWD-1]; end
      J_VERT:  begin mul_a = MW'(vgain_q); mul_b = MW'(c3m);  mul_neg = c3_q[TW-1]; end
      J_ROLL:  begin mul_a = MW'(rgain_q); mul_b = MW'(clrm); mul_neg = clr_q[CWD-1]; end
      J_PITCH: begin mul_a = MW'(pgain_q); mul_b = MW'(clpm); mul_neg = clp_q[CWD-1]; end
      J_CAM:   begin
        mul_a = MW'(rrm); mul_b = MW'(CAM_GAIN); mul_neg = rrate_q[DATA_W-1];
      end
      J_DX2:   begin mul_a = MW'(exs_q);   mul_b = MW'(exs_q); end
      default: begin mul_a = MW'(eys_q);   mul_b = MW'(eys_q); end
    endcase
  end

  qwfc_ser_mul #(.MW(MW)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .stat_o  (mstat),
    .prod_o  (prod)
  );

  // sign and round-half-up of the product
  logic signed [RW-1:0] sp, rnd_f, rnd_2f, cam_n;
  always_comb begin
    sp     = mul_neg ? -RW'(prod) : RW'(prod);
    rnd_f  = (sp + HALF_F) >>> F;
    rnd_2f = (sp + HALF_2F) >>> (2 * F);
    cam_n  = -rnd_f;
  end

  // motor mix, saturation and waypoint update
  function automatic logic [DATA_W-1:0] sat24(input logic signed [SW-1:0] v);
    logic [DATA_W-1:0] r;
    if (v > SW'(8388607))       r = 24'h7FFFFF;
    else if (v < -SW'(8388608)) r = 24'h800000;
    else                        r = v[DATA_W-1:0];
    return r;
  endfunction

  logic signed [SW-1:0] base, rin, pin;
  logic [MW:0]          dsq;
  logic [MW+5:0]        d25;
  logic                 reached;
  logic [IDX_W:0]       idx_inc;
  logic [IDX_W-1:0]     idx_d;
  logic                 done_d;

  always_comb begin
    base = SW'(hover_q) + SW'(vert_q);
    rin  = SW'(rterm_q) + SW'(rrate_q) + SW'(rdist_q);
    pin  = SW'(pterm_q) + SW'(prate_q) + SW'(pdist_q);
    dsq  = (MW + 1)'(dx2_q) + (MW + 1)'(dy2_q);
    d25  = ((MW + 6)'(dsq) << 4) + ((MW + 6)'(dsq) << 3) + (MW + 6)'(dsq);
    reached = (d25 < ((MW + 6)'(1) << (2 * F))) && alt_ok_q;
    idx_inc = {1'b0, idx_q} + 1'b1;
    idx_d   = idx_q;
    done_d  = done_q;
    if (reached) begin
      if (idx_inc < (IDX_W + 1)'(WAYPOINT_COUNT)) idx_d = idx_inc[IDX_W-1:0];
      else                                        done_d = 1'b1;
    end
  end

  logic out_load;
  assign out_load = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      job_q       <= J_SQ;
      idx_q       <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && !out_load) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE:  if (in_valid_i) state_q <= S_PREP;
        S_PREP:  begin
          job_q   <= J_SQ;
          state_q <= S_START;
        end
        S_START: state_q <= S_WAIT;
        S_WAIT:  if (mstat.done) begin
          job_q   <= job_e'(job_q + 1'b1);
          state_q <= (job_q == J_DY2) ? S_FIN : S_START;
        end
        S_FIN:   if (out_load) begin
          idx_q       <= idx_d;
          done_q      <= done_d;
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      roll_q  <= roll_angle_i;
      pitch_q <= pitch_angle_i;
      px_q    <= pos_x_i;
      py_q    <= pos_y_i;
      palt_q  <= pos_alt_i;
      rrate_q <= roll_rate_i;
      prate_q <= pitch_rate_i;
    end
    if (state_q == S_PREP) begin
      c_q      <= c_cl;
      clr_q    <= clr;
      clp_q    <= clp;
      pdist_q  <= pdist;
      rdist_q  <= rdist;
      exs_q    <= exs;
      eys_q    <= eys;
      alt_ok_q <= alt10 < (EW + 4)'(ONE_I);
    end
    if (state_q == S_WAIT && mstat.done) begin
      case (job_q)
        J_SQ:    sq_q    <= sp[MW-1:0];
        J_CUBE:  c3_q    <= rnd_2f[TW-1:0];
        J_VERT:  vert_q  <= rnd_f[TW-1:0];
        J_ROLL:  rterm_q <= rnd_f[TW-1:0];
        J_PITCH: pterm_q <= rnd_f[TW-1:0];
        J_CAM:   cam_q   <= cam_n[TW-1:0];
        J_DX2:   dx2_q   <= sp[MW-1:0];
        default: dy2_q   <= sp[MW-1:0];
      endcase
    end
    if (out_load) begin
      front_left_speed_o  <= sat24(base - rin + pin);
      front_right_speed_o <= sat24(-(base + rin + pin));
      rear_left_speed_o   <= sat24(-(base - rin - pin));
      rear_right_speed_o  <= sat24(base + rin - pin);
      camera_roll_o       <= sat24(SW'(cam_q));
      target_index_o      <= idx_d;
      point_reached_o     <= reached;
      mission_done_o      <= done_d;
    end
  end

  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |=> done_q)
    else $error("mission done flag cleared");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, idx_q} < (IDX_W + 1)'(WAYPOINT_COUNT))
    else $error("waypoint index past the list");
  a_accept_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q == S_PREP)
    else $error("accepted tick not prepared");
  a_mul_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mstat.busy)
    else $error("multiplier job issued while busy");

endmodule

// File: tb/sv/quadrotor_waypoint_flight_control_tb.sv
// Testbench for quadrotor_waypoint_flight_control: directed and random control ticks,
// register writes, waypoint walks, with an in-order scoreboard of motor commands.
// Depends on qwfc_pkg and the block's RTL.
module quadrotor_waypoint_flight_control_tb;
  import qwfc_pkg::*;

  localparam longint ONE_FX    = 64'sd4096;
  localparam longint OUT_MAX   = 64'sd8388607;
  localparam longint OUT_MIN   = -64'sd8388608;
  localparam longint CAM_K     = 64'sd471;          // 0.115 in Q12
  localparam int     LAST_WP   = 14;
  localparam int     IDLE_LIMIT = 20000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  // mission table, half meters: x, y, altitude
  localparam int WP_X[16] = '{1,1,2,2,3,3,4,4,5,5,6,6,7,7,1,1};
  localparam int WP_Y[16] = '{7,1,1,7,7,1,1,7,7,1,1,7,7,1,7,7};
  localparam int WP_A[16] = '{2,4,4,4,4,4,4,4,4,4,4,4,4,4,4,4};

  typedef struct {
    logic signed [DATA_W-1:0] roll, pitch, px, py, palt, rrate, prate;
  } tick_t;

  typedef struct {
    logic signed [DATA_W-1:0] fl, fr, rl, rr, cam;
    logic [IDX_W-1:0]         idx;
    logic                     reached, done;
  } motor_cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [DATA_W-1:0] roll_angle_i = '0, pitch_angle_i = '0, pos_x_i = '0;
  logic signed [DATA_W-1:0] pos_y_i = '0, pos_alt_i = '0, roll_rate_i = '0;
  logic signed [DATA_W-1:0] pitch_rate_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [DATA_W-1:0] front_left_speed_o, front_right_speed_o;
  logic signed [DATA_W-1:0] rear_left_speed_o, rear_right_speed_o, camera_roll_o;
  logic [IDX_W-1:0] target_index_o;
  logic point_reached_o, mission_done_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [DATA_W-1:0] cfg_data_i = '0;

  quadrotor_waypoint_flight_control dut (.*);

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  longint hover_q, alt_ofs_q, vgain_q, rgain_q, pgain_q;
  int     wp_q;
  logic   done_q;
  motor_cmd_t cmd_q[$];
  int errors = 0, n_ticks = 0, n_checked = 0, n_reached = 0, n_writes = 0;
  int burst_left = 0, idle_cycles = 0;

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // round to nearest, ties up (>>> floors)
  function automatic longint rnd_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat24(longint v);
    return DATA_W'(clampl(v, OUT_MIN, OUT_MAX));
  endfunction

  // expected motor command for one tick, advancing the waypoint state
  function automatic motor_cmd_t predict_motor_cmd(tick_t t);
    motor_cmd_t m;
    longint ex, ey, ea, pd, rd, c, c3, vert, rin, pin, base, dsq, aa;
    logic hit;
    ex = (longint'(WP_X[wp_q]) <<< 11) - longint'(t.px);
    ey = (longint'(WP_Y[wp_q]) <<< 11) - longint'(t.py);
    ea = (longint'(WP_A[wp_q]) <<< 11) - longint'(t.palt);
    pd = clampl(-2 * ex, -2 * ONE_FX, 2 * ONE_FX);
    rd = clampl(2 * ey, -2 * ONE_FX, 2 * ONE_FX);
    c = clampl(ea + alt_ofs_q, -ONE_FX, ONE_FX);
    c3 = rnd_shift(c * c * c, 24);
    vert = rnd_shift(vgain_q * c3, 12);
    rin = rnd_shift(rgain_q * clampl(longint'(t.roll), -ONE_FX, ONE_FX), 12)
          + longint'(t.rrate) + rd;
    pin = rnd_shift(pgain_q * clampl(longint'(t.pitch), -ONE_FX, ONE_FX), 12)
          + longint'(t.prate) + pd;
    base = hover_q + vert;
    aa = ea < 0 ? -ea : ea;
    dsq = ex * ex + ey * ey;
    hit = (25 * dsq < (64'sd1 <<< 24)) && (10 * aa < ONE_FX);
    if (hit) begin
      if (wp_q < LAST_WP) wp_q++;
      else done_q = 1'b1;
    end
    m.fl = sat24(base - rin + pin);
    m.fr = sat24(-(base + rin + pin));
    m.rl = sat24(-(base - rin - pin));
    m.rr = sat24(base + rin - pin);
    m.cam = sat24(-rnd_shift(longint'(t.rrate) * CAM_K, 12));
    m.idx = IDX_W'(wp_q);
    m.reached = hit;
    m.done = done_q;
    return m;
  endfunction

  // send one tick; valid stays up inside a burst, drops for a random gap after it
  task automatic send_tick(tick_t t);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    roll_angle_i <= t.roll;  pitch_angle_i <= t.pitch;
    pos_x_i <= t.px;         pos_y_i <= t.py;       pos_alt_i <= t.palt;
    roll_rate_i <= t.rrate;  pitch_rate_i <= t.prate;
    cmd_q.push_back(predict_motor_cmd(t));
    n_ticks++;
    do @(posedge clk_i); while (in_stall_o);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 300)) @(negedge clk_i);
      burst_left = $urandom_range(0, 6);
    end
  endtask

  task automatic drop_valid();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // register write, only once every expected command has come back
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    drop_valid();
    wait (cmd_q.size() == 0);
    repeat (4) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_HOVER:      hover_q = longint'(data[GAIN_W-1:0]);
      CFG_ALT_OFS:    alt_ofs_q = longint'(signed'(data));
      CFG_VERT_GAIN:  vgain_q = longint'(data[GAIN_W-1:0]);
      CFG_ROLL_GAIN:  rgain_q = longint'(data[GAIN_W-1:0]);
      CFG_PITCH_GAIN: pgain_q = longint'(data[GAIN_W-1:0]);
      default: ;
    endcase
    n_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [DATA_W-1:0] rnd_field();
    case ($urandom_range(0, 6))
      0: return 24'h7fffff;
      1: return 24'h800000;
      2: return DATA_W'(int'($urandom_range(0, 16384)) - 8192);
      3: return DATA_W'(int'($urandom_range(0, 600)) - 300);
      default: return DATA_W'($urandom);
    endcase
  endfunction

  function automatic tick_t noise_tick();
    tick_t t;
    t.roll = rnd_field();  t.pitch = rnd_field();
    t.px = rnd_field();    t.py = rnd_field();    t.palt = rnd_field();
    t.rrate = rnd_field(); t.prate = rnd_field();
    return t;
  endfunction

  // tick near the waypoint the block is steering toward
  function automatic tick_t aimed_tick(int spread);
    tick_t t;
    t = noise_tick();
    t.px = DATA_W'((WP_X[wp_q] <<< 11) + int'($urandom_range(0, 2 * spread)) - spread);
    t.py = DATA_W'((WP_Y[wp_q] <<< 11) + int'($urandom_range(0, 2 * spread)) - spread);
    t.palt = DATA_W'((WP_A[wp_q] <<< 11) + int'($urandom_range(0, 2 * spread)) - spread);
    return t;
  endfunction

  task automatic random_cfg();
    logic [CFG_IDX_W-1:0] idx;
    idx = CFG_IDX_W'($urandom_range(0, 7));
    case ($urandom_range(0, 3))
      0: write_reg(idx, 24'hffffff);
      1: write_reg(idx, 24'h000000);
      2: write_reg(idx, DATA_W'($urandom_range(0, 300000)));
      default: write_reg(idx, DATA_W'($urandom));
    endcase
  endtask

  // defaults after reset, with a few plain ticks
  task automatic test_reset_defaults();
    tick_t t;
    t = '{default: '0};
    send_tick(t);
    send_tick(aimed_tick(0));
    send_tick(aimed_tick(100));
  endtask

  // field extremes and saturation of the motor outputs
  task automatic test_field_extremes();
    tick_t t;
    t = '{default: 24'sh7fffff};
    send_tick(t);
    t = '{default: 24'sh800000};
    send_tick(t);
    t = '{roll: 24'sh001000, pitch: 24'shfff000, px: 24'sh800000, py: 24'sh7fffff,
          palt: 24'sh800000, rrate: 24'sh7fffff, prate: 24'sh800000};
    send_tick(t);
    t.roll = 24'sh800000; t.pitch = 24'sh7fffff; t.rrate = 24'sh800000;
    send_tick(t);
    // camera rounding ties
    t = '{default: '0}; t.rrate = 24'sd2048;
    send_tick(t);
    t.rrate = -24'sd2048;
    send_tick(t);
  endtask

  // register extremes, out-of-range indexes and upper data bits
  task automatic test_register_extremes();
    write_reg(CFG_HOVER, 24'hffffff);
    write_reg(CFG_ALT_OFS, 24'h7fffff);
    write_reg(CFG_VERT_GAIN, 24'hffffff);
    write_reg(CFG_ROLL_GAIN, 24'hffffff);
    write_reg(CFG_PITCH_GAIN, 24'hffffff);
    write_reg(CFG_SPARE_LO, 24'h123456);
    write_reg(CFG_SPARE_HI, 24'hffffff);
    send_tick(noise_tick());
    send_tick(noise_tick());
    write_reg(CFG_HOVER, 24'h000000);
    write_reg(CFG_ALT_OFS, 24'h800000);
    write_reg(CFG_VERT_GAIN, 24'h000000);
    write_reg(CFG_ROLL_GAIN, 24'h000000);
    write_reg(CFG_PITCH_GAIN, 24'h000000);
    send_tick(noise_tick());
    send_tick(noise_tick());
    // back to the default tuning
    write_reg(CFG_HOVER, 24'd280576);
    write_reg(CFG_ALT_OFS, 24'd2458);
    write_reg(CFG_VERT_GAIN, 24'd12288);
    write_reg(CFG_ROLL_GAIN, 24'd204800);
    write_reg(CFG_PITCH_GAIN, 24'd122880);
  endtask

  // fly the whole mission, then keep going past the last waypoint
  task automatic test_mission_walk();
    int n;
    n = 0;
    while (!done_q && n < 60) begin
      send_tick(aimed_tick(200));
      n++;
    end
    send_tick(aimed_tick(0));
    send_tick(noise_tick());
  endtask

  // random phases under changing tuning
  task automatic test_random_flight();
    for (int ph = 0; ph < 8; ph++) begin
      repeat ($urandom_range(1, 3)) random_cfg();
      repeat (215) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: send_tick(aimed_tick(300));
          4, 5:       send_tick(aimed_tick(1500));
          default:    send_tick(noise_tick());
        endcase
      end
    end
  endtask

  // receiver stall pattern: modes change every so often
  int stall_mode = 0, stall_cnt = 0;
  always @(negedge clk_i) begin
    if (stall_cnt == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_cnt = $urandom_range(50, 800);
    end
    stall_cnt--;
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 1) == 1);
      2:       out_stall_i <= ($urandom_range(0, 7) != 0);
      default: out_stall_i <= ((stall_cnt / 37) % 2 == 1);
    endcase
  end

  task automatic report_mismatch(string fld, int got, int want);
    errors++;
    $display("mismatch at command %0d: %s got %0d expected %0d", n_checked, fld, got, want);
  endtask

  // compare each output transfer with the oldest expectation
  always @(posedge clk_i) begin
    motor_cmd_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (cmd_q.size() == 0) begin
        errors++;
        $display("unexpected output transfer");
      end else begin
        e = cmd_q.pop_front();
        if (front_left_speed_o !== e.fl) report_mismatch("front_left", front_left_speed_o, e.fl);
        if (front_right_speed_o !== e.fr)
          report_mismatch("front_right", front_right_speed_o, e.fr);
        if (rear_left_speed_o !== e.rl) report_mismatch("rear_left", rear_left_speed_o, e.rl);
        if (rear_right_speed_o !== e.rr) report_mismatch("rear_right", rear_right_speed_o, e.rr);
        if (camera_roll_o !== e.cam) report_mismatch("camera_roll", camera_roll_o, e.cam);
        if (target_index_o !== e.idx) report_mismatch("target_index", target_index_o, e.idx);
        if (point_reached_o !== e.reached)
          report_mismatch("point_reached", point_reached_o, e.reached);
        if (mission_done_o !== e.done) report_mismatch("mission_done", mission_done_o, e.done);
        if (e.reached) n_reached++;
        n_checked++;
      end
    end
  end

  // watchdog on cycles with no transfer on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else if (rst_ni) begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    hover_q = 280576; alt_ofs_q = 2458; vgain_q = 12288; rgain_q = 204800; pgain_q = 122880;
    wp_q = 0; done_q = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_field_extremes();
    test_register_extremes();
    test_mission_walk();
    test_random_flight();
    drop_valid();
    wait (cmd_q.size() == 0);
    repeat (300) @(posedge clk_i);
    $display("covered %0d ticks, %0d checked, %0d waypoint hits, %0d register writes",
             n_ticks, n_checked, n_reached, n_writes);
    $display("final waypoint %0d, mission done %0b, mismatches %0d", wp_q, done_q, errors);
    if (errors == 0 && cmd_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
